[rtl/rpn_pkg.sv]
package rpn_pkg;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int DATA_W = 64;
  localparam int TOL_W = 63;
  localparam logic [63:0] TARGET_RESET = 64'd42949672960;
  localparam logic [62:0] TOL_RESET = 63'd4294967;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_FULL  = 3'd2,
    ERR_DIVZ  = 3'd3,
    ERR_OVF   = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_TOL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_tok;   // capture input item
    logic push;       // write operand at count
    logic op_start;   // latch a, b and start arithmetic
    logic note_under; // operator with fewer than two entries
    logic mul_step;   // accumulate one partial product
    logic div_step;   // one quotient bit
    logic op_write;   // write arithmetic result, pop one
    logic finish;     // form result, clear stack
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic [1:0] op;
    logic last;
    logic full;
    logic few;
    logic divz;
    logic mul_done;
    logic div_done;
  } stat_t;
endpackage

[rtl/rpn_ctrl.sv]
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_MUL, S_DIV, S_WR, S_RD, S_FIN} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    cmd = '0;
    cmd.load_tok = in_valid && in_ready;
    unique case (state)
      S_DEC: begin
        if (!st.is_op) cmd.push = 1'b1;
        else if (!st.few) cmd.op_start = 1'b1;
        else cmd.note_under = 1'b1;
      end
      S_MUL: cmd.mul_step = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_WR: cmd.op_write = 1'b1;
      S_FIN: cmd.finish = !(out_valid && !out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: if (cmd.load_tok) state <= S_DEC;
        S_DEC: begin
          if (st.is_op && !st.few) begin
            priority if (st.op == OP_MUL) state <= S_MUL;
            else if (st.op == OP_DIV && !st.divz) state <= S_DIV;
            else state <= S_WR;
          end else state <= st.last ? S_RD : S_IDLE;
        end
        S_MUL: if (st.mul_done) state <= S_WR;
        S_DIV: if (st.div_done) state <= S_WR;
        S_WR: state <= st.last ? S_RD : S_IDLE;
        // registered top-of-stack read settles
        S_RD: state <= S_FIN;
        S_FIN: if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/rpn_dpath.sv]
module rpn_dpath
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        tok_is_op,
  input  logic [1:0]  tok_op,
  input  logic [63:0] tok_val,
  input  logic        tok_last,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  output logic [63:0] res_value,
  output logic [2:0]  res_err,
  output logic        res_match
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [63:0] mem [STACK_DEPTH];
  logic [CW-1:0] cnt;
  err_t err;
  logic [63:0] target;
  logic [62:0] tol;
  logic is_op, last;
  logic [1:0] op;
  logic [63:0] val;
  logic [63:0] ra, rb;
  logic [63:0] rd_a, rd_b;
  logic [63:0] top;
  logic neg;
  logic [63:0] xm, ym;
  logic [1:0] mstep;
  logic [127:0] macc;
  logic [6:0] dstep;
  logic [63:0] rem, q;
  logic dovf;
  logic [63:0] r;
  logic r_ovf;
  err_t r_err;

  assign st.is_op = is_op;
  assign st.op = op;
  assign st.last = last;
  assign st.full = cnt >= CW'(STACK_DEPTH);
  assign st.few = cnt < CW'(2);
  assign st.divz = (rd_b == 64'd0) && (op == OP_DIV);
  assign st.mul_done = mstep == 2'd3;
  assign st.div_done = dstep == 7'd95;

  // operands a (below top) and b (top) read in registered form during S_DEC
  always_ff @(posedge clk) begin
    rd_b <= mem[AW'(cnt - CW'(1))];
    rd_a <= mem[AW'(cnt - CW'(2))];
    top <= mem[AW'(cnt - CW'(1))];
  end

  // partial product select
  logic [31:0] px, py;
  logic [63:0] pp;
  always_comb begin
    px = mstep[0] ? xm[63:32] : xm[31:0];
    py = mstep[1] ? ym[63:32] : ym[31:0];
    pp = px * py;
  end
  logic [127:0] macc_next;
  assign macc_next = macc + ({64'd0, pp} << (32 * (int'(mstep[0]) + int'(mstep[1]))));

  // divide step
  logic [64:0] rsh;
  logic dbit, qb;
  logic [64:0] rsub;
  always_comb begin
    dbit = (dstep <= 7'd63) ? xm[6'(7'd63 - dstep)] : 1'b0;
    rsh = {rem, dbit};
    rsub = rsh - {1'b0, ym};
    qb = !rsub[64];
  end

  // arithmetic result
  logic [64:0] s;
  logic [63:0] mag;
  logic mov;
  always_comb begin
    r = 64'd0;
    r_ovf = 1'b0;
    r_err = ERR_OVF;
    s = '0;
    mag = '0;
    mov = 1'b0;
    unique case (op)
      OP_ADD, OP_SUB: begin
        s = (op == OP_ADD) ? {ra[63], ra} + {rb[63], rb} : {ra[63], ra} - {rb[63], rb};
        r = s[63:0];
        if (s[64] != s[63]) begin
          r_ovf = 1'b1;
          r = s[64] ? MIN_NEG : MAX_POS;
        end
      end
      OP_MUL, OP_DIV: begin
        if (op == OP_MUL) begin
          mag = macc[95:32];
          mov = macc[127:96] != 32'd0;
        end else begin
          mag = q;
          mov = dovf;
        end
        if (op == OP_DIV && rb == 64'd0) begin
          r_err = ERR_DIVZ;
          r_ovf = 1'b1;
          r = (ra == 64'd0) ? 64'd0 : (ra[63] ? MIN_NEG : MAX_POS);
        end else if (neg) begin
          r_ovf = mov || (mag > MIN_NEG);
          r = r_ovf ? MIN_NEG : 64'd0 - mag;
        end else begin
          r_ovf = mov || mag[63];
          r = r_ovf ? MAX_POS : mag;
        end
      end
      default: ;
    endcase
  end

  // final result
  logic [63:0] fres, diff;
  err_t ferr;
  always_comb begin
    fres = (cnt == CW'(0)) ? 64'd0 : top;
    ferr = err;
    if (cnt == CW'(0) && err == ERR_NONE) ferr = ERR_UNDER;
    diff = ($signed(fres) >= $signed(target)) ? fres - target : target - fres;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !st.full) mem[AW'(cnt)] <= val;
    if (cmd.op_write) mem[AW'(cnt - CW'(2))] <= r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      is_op <= tok_is_op;
      op <= tok_op;
      val <= tok_val;
      last <= tok_last;
    end
    if (cmd.op_start) begin
      ra <= rd_a;
      rb <= rd_b;
      neg <= rd_a[63] ^ rd_b[63];
      xm <= rd_a[63] ? 64'd0 - rd_a : rd_a;
      ym <= rd_b[63] ? 64'd0 - rd_b : rd_b;
      mstep <= 2'd0;
      macc <= '0;
      dstep <= 7'd0;
      rem <= 64'd0;
      q <= 64'd0;
      dovf <= 1'b0;
    end
    if (cmd.mul_step) begin
      macc <= macc_next;
      mstep <= mstep + 2'd1;
    end
    if (cmd.div_step) begin
      rem <= (rsh[64] || qb) ? 64'(rsh - {1'b0, ym}) : rsh[63:0];
      if (q[63]) dovf <= 1'b1;
      q <= {q[62:0], rsh[64] || qb};
      dstep <= dstep + 7'd1;
    end
    if (cmd.finish) begin
      res_value <= fres;
      res_err <= ferr;
      res_match <= (ferr == ERR_NONE) && (diff < {1'b0, tol});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      err <= ERR_NONE;
      target <= TARGET_RESET;
      tol <= TOL_RESET;
    end else begin
      if (cfg_we && cfg_idx == REG_TARGET) target <= cfg_data;
      if (cfg_we && cfg_idx == REG_TOL) tol <= cfg_data[62:0];
      if (cmd.push) begin
        if (st.full) begin
          if (err == ERR_NONE) err <= ERR_FULL;
        end else cnt <= cnt + CW'(1);
      end
      if (cmd.op_write) begin
        cnt <= cnt - CW'(1);
        if (r_ovf && err == ERR_NONE) err <= r_err;
      end
      if (cmd.note_under && err == ERR_NONE) err <= ERR_UNDER;
      if (cmd.finish) begin
        cnt <= '0;
        err <= ERR_NONE;
      end
    end
  end
endmodule

[rtl/rpn_stack_evaluator.sv]
// RPN evaluator over signed Q32.32. One token per s_axis item; the result
// (value, error code, target match) appears on m_axis after the item marked
// tlast. Items are taken in S_IDLE only; an operand passes S_DEC,
// add/subtract or a divide by zero S_DEC and S_WR, multiply S_DEC, S_MUL
// (four 32x32 partial products through one multiplier) and S_WR, divide
// S_DEC, S_DIV (one quotient bit per cycle over the 96-bit shifted dividend)
// and S_WR; the item marked last then adds S_RD and S_FIN to read the top of
// the stack and form the result. Input is held while a result waits on m_axis.
module rpn_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // op_code[1:0], operand_value[65:2], zero pad
  input  logic        s_axis_tuser,  // is_operator
  input  logic        s_axis_tlast,  // last_token
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // result_value
  output logic [7:0]  m_axis_tuser,  // error_code[2:0], matches_target[3], zero pad
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data
);
  cmd_t cmd;
  stat_t st;
  logic [2:0] err;
  logic match;

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .st(st), .cmd(cmd)
  );

  rpn_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .tok_is_op(s_axis_tuser), .tok_op(s_axis_tdata[1:0]),
    .tok_val(s_axis_tdata[65:2]), .tok_last(s_axis_tlast),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .res_value(m_axis_tdata), .res_err(err), .res_match(match)
  );

  assign m_axis_tuser = {4'd0, match, err};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(match && err != ERR_NONE))
    else $error("match with error");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.op_start |-> !s_axis_tready)
    else $error("accept while busy");
endmodule

[tb/sv/rpn_checker.sv]
module rpn_checker
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [7:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0] value;
    err_t        err;
    logic        hit;
  } eval_result_t;

  logic [63:0]  stk [STACK_DEPTH];
  int           depth_used;
  err_t         first_err;
  logic [63:0]  goal;
  logic [62:0]  tol;
  eval_result_t result_q[$];

  function automatic void flag(err_t e);
    if (first_err == ERR_NONE) first_err = e;
  endfunction

  function automatic logic [63:0] mag_of(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] sat_sign(logic [63:0] m, logic neg, logic ovf);
    if (neg) begin
      if (ovf || m > MIN_NEG) begin
        flag(ERR_OVF);
        return MIN_NEG;
      end
      return -m;
    end
    if (ovf || m > MAX_POS) begin
      flag(ERR_OVF);
      return MAX_POS;
    end
    return m;
  endfunction

  function automatic logic [63:0] q_arith(op_t op, logic [63:0] a, logic [63:0] b);
    logic [63:0]  s;
    logic [127:0] p;
    logic [127:0] q;
    case (op)
      OP_ADD, OP_SUB: begin
        s = (op == OP_ADD) ? a + b : a - b;
        if (((op == OP_ADD) ? (a[63] == b[63]) : (a[63] != b[63])) && s[63] != a[63]) begin
          flag(ERR_OVF);
          return a[63] ? MIN_NEG : MAX_POS;
        end
        return s;
      end
      OP_MUL: begin
        p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
        return sat_sign(p[95:32], a[63] ^ b[63], p[127:96] != 0);
      end
      default: begin
        if (b == 0) begin
          flag(ERR_DIVZ);
          if (a == 0) return 64'd0;
          return a[63] ? MIN_NEG : MAX_POS;
        end
        q = {32'd0, mag_of(a), 32'd0} / {64'd0, mag_of(b)};
        return sat_sign(q[63:0], a[63] ^ b[63], q[127:64] != 0);
      end
    endcase
  endfunction

  task automatic take_token(logic is_op, op_t op, logic [63:0] val, logic last);
    eval_result_t r;
    logic [63:0]  diff;
    if (!is_op) begin
      if (depth_used >= STACK_DEPTH) flag(ERR_FULL);
      else begin
        stk[depth_used] = val;
        depth_used++;
      end
    end else if (depth_used < 2) begin
      flag(ERR_UNDER);
    end else begin
      stk[depth_used-2] = q_arith(op, stk[depth_used-2], stk[depth_used-1]);
      depth_used--;
    end
    if (last) begin
      r.value = 64'd0;
      if (depth_used == 0) flag(ERR_UNDER);
      else r.value = stk[depth_used-1];
      r.hit = 1'b0;
      if (first_err == ERR_NONE) begin
        diff = ($signed(r.value) >= $signed(goal)) ? r.value - goal : goal - r.value;
        r.hit = diff < {1'b0, tol};
      end
      r.err = first_err;
      result_q = {result_q, r};
      depth_used = 0;
      first_err = ERR_NONE;
    end
  endtask

  always @(posedge clk) begin
    eval_result_t e;
    if (rst) begin
      depth_used = 0;
      first_err = ERR_NONE;
      goal = TARGET_RESET;
      tol = TOL_RESET;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_TARGET) goal = cfg_data;
        else tol = cfg_data[62:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        take_token(s_axis_tuser, op_t'(s_axis_tdata[1:0]), s_axis_tdata[65:2], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result value=%h user=%h", $time, m_axis_tdata,
                   m_axis_tuser);
          fail_count++;
        end else begin
          e = result_q.pop_front();
          if (m_axis_tdata !== e.value) begin
            $display("%0t: result_value expected %h actual %h", $time, e.value,
                     m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tuser[2:0] !== e.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, e.err,
                     m_axis_tuser[2:0]);
            fail_count++;
          end
          if (m_axis_tuser[3] !== e.hit) begin
            $display("%0t: matches_target expected %b actual %b", $time, e.hit,
                     m_axis_tuser[3]);
            fail_count++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top
  import rpn_pkg::*;
;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        cfg_we;
  logic        cfg_idx;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;
  logic        calm;

  rpn_stack_evaluator u_dut (.*);
  rpn_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end

  // output stall
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 17);
  end

  function automatic logic [63:0] rand_val();
    case ($urandom_range(7))
      0: return MAX_POS;
      1: return MIN_NEG;
      2: return 64'd0;
      3: return {$urandom, $urandom};
      4: return {{28{1'b0}}, 4'($urandom_range(10)), 32'd0};
      5: return -{{28{1'b0}}, 4'($urandom_range(10)), 32'd0};
      6: return {{16{$urandom_range(1) ? 1'b1 : 1'b0}}, 16'($urandom), $urandom};
      default: return {{24{1'b0}}, 8'($urandom), $urandom};
    endcase
  endfunction

  task automatic send(logic is_op, op_t op, logic [63:0] val, logic last);
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= is_op;
    s_axis_tlast <= last;
    s_axis_tdata <= {6'd0, val, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // expression with n operands, random ops; n of 1 sends a second operand as last
  task automatic rand_expr(int n);
    int live;
    int pushed;
    live = 0;
    pushed = 0;
    while (pushed < n || live > 1) begin
      if (pushed < n && (live < 2 || $urandom_range(1))) begin
        send(1'b0, OP_ADD, rand_val(), 1'b0);
        pushed++;
        live++;
      end else begin
        send(1'b1, op_t'($urandom_range(3)), rand_val(), live == 2 && pushed == n ? 1'b1 : 1'b0);
        live--;
      end
    end
    if (n == 1) send(1'b0, OP_ADD, rand_val(), 1'b1);
  endtask

  initial begin
    int sent;
    int k;
    int n;
    rst = 1'b1;
    calm = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_TARGET;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 10 = 4 + 6 at reset target
    send(1'b0, OP_ADD, 64'h4_0000_0000, 1'b0);
    send(1'b0, OP_ADD, 64'h6_0000_0000, 1'b0);
    send(1'b1, OP_ADD, '0, 1'b1);
    send(1'b0, OP_ADD, MIN_NEG, 1'b0);
    send(1'b0, OP_ADD, 64'h1, 1'b0);
    send(1'b1, OP_SUB, '0, 1'b1);
    send(1'b0, OP_ADD, MAX_POS, 1'b0);
    send(1'b0, OP_ADD, MAX_POS, 1'b0);
    send(1'b1, OP_MUL, '0, 1'b1);
    send(1'b0, OP_ADD, MIN_NEG, 1'b0);
    send(1'b0, OP_ADD, 64'hFFFF_FFFF_0000_0000, 1'b0);
    send(1'b1, OP_DIV, '0, 1'b1);
    send(1'b0, OP_ADD, 64'h5_0000_0000, 1'b0);
    send(1'b0, OP_ADD, 64'd0, 1'b0);
    send(1'b1, OP_DIV, '0, 1'b1);
    send(1'b1, OP_ADD, '0, 1'b1);
    for (k = 0; k < 9; k++) send(1'b0, OP_ADD, 64'(k), k == 8);
    send(1'b0, OP_ADD, 64'd3, 1'b0);
    send(1'b0, OP_ADD, 64'd2, 1'b1);
    drain();

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_TARGET, MAX_POS); write_reg(REG_TOL, 64'd0); end
        1: begin write_reg(REG_TARGET, MIN_NEG); write_reg(REG_TOL, MAX_POS); end
        2: begin
          write_reg(REG_TARGET, 64'h18_0000_0000);
          write_reg(REG_TOL, 64'hFFFF_FFFF);
        end
        3: begin write_reg(REG_TARGET, 64'd0); write_reg(REG_TOL, 64'hFFFF_FFFF_FFFF_FFFF); end
        4: begin
          write_reg(REG_TARGET, {$urandom, $urandom});
          write_reg(REG_TOL, {$urandom, $urandom});
        end
        default: begin
          write_reg(REG_TARGET, 64'hA_0000_0000);
          write_reg(REG_TOL, 64'd4294967);
        end
      endcase
      cfg_we <= 1'b0;
      calm = (phase == 3);
      while (sent < (phase + 1) * 185) begin
        k = $urandom_range(9);
        if (k == 0) begin
          send($urandom_range(1), op_t'($urandom_range(3)), rand_val(), $urandom_range(3) == 0);
          sent++;
        end else begin
          n = $urandom_range(1, 10);
          rand_expr(n);
          sent += (n == 1) ? 2 : 2 * n - 1;
        end
      end
      send(1'b0, OP_ADD, rand_val(), 1'b1);
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
